// ----- rtl/core/bit_range_move_engine_defines.svh -----
// assertion macros for the bit range move engine
// no dependencies; included by the files that check their own logic
`ifndef BIT_RANGE_MOVE_ENGINE_DEFINES_SVH
`define BIT_RANGE_MOVE_ENGINE_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define BRME_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("brme check failed");

// expression that must never be true outside reset
`define BRME_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("brme forbidden condition");

`endif

// ----- rtl/core/brme_pkg.sv -----
// types, constants and codes of the bit range move engine
// no dependencies
`timescale 1ns / 1ps

package brme_pkg;

  localparam int WORD_COUNT = 1024;
  localparam int AW = $clog2(WORD_COUNT);
  localparam int SUM_W = (AW + 6 > 17) ? AW + 6 : 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] TOTAL_BITS = SUM_W'(WORD_COUNT * 32);
  localparam logic [31:0] ONES = 32'hffffffff;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_MOVE  = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_MOVE,
    CMD_DONE,
    CMD_FAIL
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_SRC0,
    ST_SRC1,
    ST_DST,
    ST_MERGE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  word_address;
    logic [31:0] word_data;
    logic [9:0]  source_base;
    logic [9:0]  dest_base;
    logic [14:0] bit_begin;
    logic [15:0] bit_end;
    logic [14:0] bit_dest;
  } brme_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
  } brme_rsp_t;

  typedef struct packed {
    cmd_e          kind;
    logic [AW-1:0] addr;
    logic [31:0]   data;
    logic          down;
    logic [AW-1:0] sw_ofs;
    logic [4:0]    off;
    logic [AW-1:0] fw;
    logic [AW-1:0] lw;
    logic [4:0]    lo_off;
    logic [4:0]    hi_off;
  } cmd_t;

endpackage

// ----- rtl/core/brme_front.sv -----
// front end: accepts requests, checks ranges and builds commands
// depends on brme_pkg
`timescale 1ns / 1ps

module brme_front import brme_pkg::*; (
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  brme_req_t in_req_i,
  output logic      push_o,
  output cmd_t      cmd_o,
  input  logic      full_i
);

  logic [SUM_W-1:0] src, dst, send, dend, dend_m1, diff;
  logic [15:0]      len;
  logic             addr_ok, range_bad;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    src     = (SUM_W'(in_req_i.source_base) << 5) + SUM_W'(in_req_i.bit_begin);
    dst     = (SUM_W'(in_req_i.dest_base) << 5) + SUM_W'(in_req_i.bit_dest);
    send    = (SUM_W'(in_req_i.source_base) << 5) + SUM_W'(in_req_i.bit_end);
    len     = in_req_i.bit_end - 16'(in_req_i.bit_begin);
    dend    = dst + SUM_W'(len);
    dend_m1 = dend - SUM_W'(1);
    diff    = src - dst;
    addr_ok = 32'(in_req_i.word_address) < 32'(WORD_COUNT);
    range_bad = ({1'b0, in_req_i.bit_begin} >= in_req_i.bit_end)
             || (send > TOTAL_BITS) || (dend > TOTAL_BITS);

    cmd_o.addr   = AW'(in_req_i.word_address);
    cmd_o.data   = in_req_i.word_data;
    cmd_o.down   = dst > src;
    cmd_o.sw_ofs = diff[AW+4:5];
    cmd_o.off    = diff[4:0];
    cmd_o.fw     = dst[AW+4:5];
    cmd_o.lw     = dend_m1[AW+4:5];
    cmd_o.lo_off = dst[4:0];
    cmd_o.hi_off = dend[4:0];

    unique case (op_e'(in_req_i.operation))
      OP_WRITE: cmd_o.kind = addr_ok ? CMD_WRITE : CMD_FAIL;
      OP_READ:  cmd_o.kind = addr_ok ? CMD_READ : CMD_FAIL;
      OP_MOVE: begin
        if (range_bad) begin
          cmd_o.kind = CMD_FAIL;
        end else if (dst == src) begin
          cmd_o.kind = CMD_DONE;
        end else begin
          cmd_o.kind = CMD_MOVE;
        end
      end
      default: cmd_o.kind = CMD_FAIL;
    endcase
  end

endmodule

// ----- rtl/core/brme_fifo.sv -----
// short command queue between front and back end
// depends on brme_pkg
`timescale 1ns / 1ps

module brme_fifo import brme_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t           entry_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   count_q;

  assign full_o  = count_q == (QAW+1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QAW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QAW+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/core/brme_back.sv -----
// back end: word store, read-modify-write sequencer and result register
// depends on brme_pkg and bit_range_move_engine_defines.svh
`timescale 1ns / 1ps
`include "bit_range_move_engine_defines.svh"

module brme_back import brme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output brme_rsp_t out_rsp_o
);

  state_e        state_q, state_d;
  cmd_t          cmd_q;
  logic [AW-1:0] cur_q;
  logic [31:0]   s0_q, s1_q, rdata_q;
  logic [31:0]   store_q [WORD_COUNT];
  logic          out_valid_q;
  brme_rsp_t     out_q;

  logic          re, we, load_out, last_word;
  logic [AW-1:0] raddr, waddr, sw0;
  logic [31:0]   wdata, m_lo, m_hi, mask, src_word;
  logic [63:0]   shifted;

  assign sw0       = cur_q + cmd_q.sw_ofs;
  assign shifted   = {s0_q, s1_q} << cmd_q.off;
  assign src_word  = shifted[63:32];
  assign m_lo      = (cur_q == cmd_q.fw) ? (ONES >> cmd_q.lo_off) : ONES;
  assign m_hi      = (cur_q == cmd_q.lw && cmd_q.hi_off != 5'd0) ?
                     ~(ONES >> cmd_q.hi_off) : ONES;
  assign mask      = m_lo & m_hi;
  assign last_word = cur_q == (cmd_q.down ? cmd_q.fw : cmd_q.lw);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_WRITE: state_d = ST_WRITE;
            CMD_READ:  state_d = ST_READ;
            CMD_MOVE:  state_d = ST_SRC0;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_WRITE: state_d = ST_RESP;
      ST_READ:  state_d = ST_RESP;
      ST_SRC0:  state_d = ST_SRC1;
      ST_SRC1:  state_d = ST_DST;
      ST_DST:   state_d = ST_MERGE;
      ST_MERGE: state_d = last_word ? ST_RESP : ST_SRC0;
      ST_RESP:  state_d = load_out ? ST_IDLE : ST_RESP;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    re          = 1'b0;
    raddr       = cur_q;
    we          = 1'b0;
    waddr       = cur_q;
    wdata       = (rdata_q & ~mask) | (src_word & mask);
    cmd_ready_o = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE:  cmd_ready_o = 1'b1;
      ST_WRITE: begin
        we    = 1'b1;
        waddr = cmd_q.addr;
        wdata = cmd_q.data;
      end
      ST_READ: begin
        re    = 1'b1;
        raddr = cmd_q.addr;
      end
      ST_SRC0: begin
        re    = 1'b1;
        raddr = sw0;
      end
      ST_SRC1: begin
        re    = 1'b1;
        raddr = sw0 + AW'(1);
      end
      ST_DST: begin
        re    = 1'b1;
        raddr = cur_q;
      end
      ST_MERGE: we = 1'b1;
      ST_RESP:  load_out = !out_valid_q || out_ready_i;
      default:  cmd_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= store_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_SRC1) begin
      s0_q <= rdata_q;
    end
    if (state_q == ST_DST) begin
      s1_q <= rdata_q;
    end
    if (load_out) begin
      out_q.read_data <= (cmd_q.kind == CMD_READ) ? rdata_q : 32'd0;
      out_q.status    <= cmd_q.kind == CMD_FAIL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_ready_o && cmd_valid_i) begin
        cur_q <= cmd_i.down ? cmd_i.lw : cmd_i.fw;
      end else if (state_q == ST_MERGE && !last_word) begin
        cur_q <= cmd_q.down ? cur_q - AW'(1) : cur_q + AW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `BRME_ASSERT(a_merge_in_span, clk_i, rst_ni, (state_q == ST_MERGE) |-> (cur_q >= cmd_q.fw && cur_q <= cmd_q.lw))
  `BRME_ASSERT_NEVER(a_write_state, clk_i, rst_ni, we && !(state_q == ST_WRITE || state_q == ST_MERGE))
  `BRME_ASSERT(a_resp_loads, clk_i, rst_ni, (state_q == ST_RESP && state_d == ST_IDLE) |=> out_valid_q)
  `BRME_ASSERT_NEVER(a_read_write_clash, clk_i, rst_ni, re && we)

endmodule

// ----- rtl/core/bit_range_move_engine.sv -----
// top level of the bit range move engine: front end, command queue, back end
// depends on brme_pkg, brme_front, brme_fifo and brme_back
`timescale 1ns / 1ps

// requests enter on in_valid_i/in_ready_o with in_req_i; every request gives
// exactly one response on out_valid_o/out_ready_i with out_rsp_o, in order
// a request writes a word, reads a word, or moves a bit range between regions
// of a 1024 x 32 word store, bits numbered from the msb of each word
// the front end checks ranges in the accept cycle and queues a command
// (two entries), so requests are taken while the back end is busy
// the back end runs one command at a time over a single-port store:
// a write or read passes through its WRITE or READ state, then leaves from
// RESP through the result register; a failed check or a move onto itself
// goes straight to RESP; a move walks each destination word with a
// read-modify-write through SRC0, SRC1, DST and MERGE, then goes to RESP
// results wait in the output register while the receiver stalls; the back
// end then holds and the queue fills before in_ready_o drops
// reset clears control state and the queue; store contents are undefined
// until written, with no clearing pass

module bit_range_move_engine import brme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  brme_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output brme_rsp_t out_rsp_o
);

  logic push, full, q_valid, pop;
  cmd_t cmd_in, cmd_out;

  brme_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .full_i     (full)
  );

  brme_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (cmd_out)
  );

  logic back_ready;
  assign pop = q_valid && back_ready;

  brme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd_out),
    .cmd_ready_o (back_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
